// ===== rtl/srr_pkg.sv =====
// Shared types, constants and helpers of the selective-repeat receiver.
`default_nettype none

package srr_pkg;

  // Field widths
  localparam int KIND_W = 2;
  localparam int SEQ_W  = 15;
  localparam int LEN_W  = 11;
  localparam int TAG_W  = 8;
  localparam int EV_W   = 2;
  localparam int CFG_W  = 14;

  // Protocol limits
  localparam int MAX_SEQ      = 32767;
  localparam int MAX_PAYLOAD  = 1024;
  localparam int WINDOW_SLOTS = 8;
  localparam int HALF_SEQ     = MAX_SEQ / 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_SYN    = 2'd0,
    KIND_STATUS = 2'd1,
    KIND_DATA   = 2'd2,
    KIND_FIN    = 2'd3
  } kind_t;

  typedef enum logic [EV_W-1:0] {
    EV_ACK     = 2'd0,
    EV_DATA    = 2'd1,
    EV_STATUS  = 2'd2
  } event_t;

  // One result without the last flag
  typedef struct packed {
    logic [EV_W-1:0]  ev;
    logic [SEQ_W-1:0] seq;
    logic [LEN_W-1:0] len;
    logic [TAG_W-1:0] tag;
    logic             rt;
    logic             fa;
  } res_t;

  // One reorder window entry
  typedef struct packed {
    logic [SEQ_W-1:0] seq;
    logic [LEN_W-1:0] len;
    logic [TAG_W-1:0] tag;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  // Any sequence value past the maximum becomes zero
  function automatic logic [SEQ_W-1:0] wrap_seq(input logic [SEQ_W:0] v);
    return (32'(v) > MAX_SEQ) ? '0 : v[SEQ_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/selective_repeat_receiver.sv =====
// Top level of the selective-repeat receiver: header classification, window and drain.
// One header at a time; in_stall is high from acceptance until the last result is queued,
// and while cfg_valid is high. Early data takes a full read scan of the window RAM; in-order
// data is followed by one scan of the window per buffered entry released or dropped and a
// final scan that finds none to take. Sync reset: expected seq 1, slots cleared.
`default_nettype none

module selective_repeat_receiver
  import srr_pkg::*;
#(
  parameter int WINDOW = WINDOW_SLOTS
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // configuration
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [CFG_W-1:0]   cfg_initial_seq,
  // headers in
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [KIND_W-1:0]  in_kind,
  input  wire logic [SEQ_W-1:0]   in_seq,
  input  wire logic [LEN_W-1:0]   in_length,
  input  wire logic [TAG_W-1:0]   in_tag,
  // results out
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [EV_W-1:0]         out_event_res,
  output logic [SEQ_W-1:0]        out_ack_seq,
  output logic [LEN_W-1:0]        out_length,
  output logic [TAG_W-1:0]        out_tag,
  output logic                    out_retransmitted,
  output logic                    out_fin_ack,
  output logic                    out_last
);

  localparam int AW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam logic [SEQ_W:0] HALF = (SEQ_W+1)'(HALF_SEQ);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_CLASS = 8'b0000_0010,
    S_DELIV = 8'b0000_0100,
    S_WSCAN = 8'b0000_1000,
    S_WDEC  = 8'b0001_0000,
    S_DSCAN = 8'b0010_0000,
    S_DACT  = 8'b0100_0000,
    S_FLUSH = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [CFG_W-1:0]  init_r, init_nxt;
  logic [SEQ_W-1:0]  exp_r, exp_nxt;
  logic [WINDOW-1:0] valid_r, valid_nxt;

  logic [KIND_W-1:0] pkt_kind_r, pkt_kind_nxt;
  logic [SEQ_W-1:0]  pkt_seq_r, pkt_seq_nxt;
  logic [LEN_W-1:0]  pkt_len_r, pkt_len_nxt;
  logic [TAG_W-1:0]  pkt_tag_r, pkt_tag_nxt;

  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [AW-1:0]     rd_idx_r;
  logic              hit_r, hit_nxt;
  logic              found_r, found_nxt;
  logic [AW-1:0]     best_idx_r, best_idx_nxt;
  slot_t             best_r, best_nxt;

  res_t              pend_r, pend_nxt;
  logic              pend_valid_r, pend_valid_nxt;
  res_t              out_res_r, out_res_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  slot_t             ram_wslot;
  logic [SLOT_W-1:0] ram_rdata;
  slot_t             rd_slot;

  logic              idle;
  logic              out_free;
  logic              can_emit;
  logic              emit_req;
  res_t              emit_res;
  logic              flush_req;
  logic [SEQ_W:0]    e16;
  logic [SEQ_W:0]    s16;
  logic [SEQ_W-1:0]  start_seq;
  logic              is_dup;
  logic              is_early;
  logic              in_order;
  logic              free_any;
  logic [AW-1:0]     free_idx;
  logic              eval;

  srr_ram #(
    .WIDTH(SLOT_W),
    .DEPTH(WINDOW)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wslot),
    .raddr(cnt_r[AW-1:0]),
    .rdata(ram_rdata)
  );

  assign rd_slot = slot_t'(ram_rdata);

  // Handshake
  assign idle      = (state_r == S_IDLE);
  assign cfg_ready = idle;
  assign in_stall  = !idle || cfg_valid;
  assign out_free  = !out_valid_r || !out_stall;
  assign can_emit  = !pend_valid_r || out_free;

  // Window classification of the held header
  assign e16       = {1'b0, exp_r};
  assign s16       = {1'b0, pkt_seq_r};
  assign start_seq = wrap_seq({2'b00, init_r} + (SEQ_W+1)'(1));
  assign in_order  = (pkt_seq_r == exp_r);
  assign is_dup    = ((s16 < e16) && (s16 + HALF >= e16)) || ((exp_r == '0) && (s16 >= HALF));
  assign is_early  = (s16 > e16) && (s16 < e16 + HALF);

  // Lowest free slot
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = WINDOW - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_any = 1'b1;
        free_idx = AW'(i);
      end
    end
  end

  assign eval = (cnt_r != '0);

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    init_nxt       = init_r;
    exp_nxt        = exp_r;
    valid_nxt      = valid_r;
    pkt_kind_nxt   = pkt_kind_r;
    pkt_seq_nxt    = pkt_seq_r;
    pkt_len_nxt    = pkt_len_r;
    pkt_tag_nxt    = pkt_tag_r;
    cnt_nxt        = cnt_r;
    hit_nxt        = hit_r;
    found_nxt      = found_r;
    best_idx_nxt   = best_idx_r;
    best_nxt       = best_r;
    emit_req       = 1'b0;
    emit_res       = '0;
    flush_req      = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = free_idx;
    ram_wslot      = '{seq: pkt_seq_r, len: pkt_len_r, tag: pkt_tag_r};

    unique case (state_r)
      S_IDLE: begin
        if (cfg_valid) begin
          // new session
          init_nxt  = cfg_initial_seq;
          exp_nxt   = wrap_seq({2'b00, cfg_initial_seq} + (SEQ_W+1)'(1));
          valid_nxt = '0;
        end else if (in_valid) begin
          pkt_kind_nxt = in_kind;
          pkt_seq_nxt  = in_seq;
          pkt_len_nxt  = (32'(in_length) > MAX_PAYLOAD) ? LEN_W'(MAX_PAYLOAD) : in_length;
          pkt_tag_nxt  = in_tag;
          state_nxt    = S_CLASS;
        end
      end

      S_CLASS: begin
        state_nxt = S_FLUSH;
        unique case (kind_t'(pkt_kind_r))
          KIND_SYN: begin
            emit_req = 1'b1;
            emit_res = '{ev: EV_ACK, seq: pkt_seq_r, len: '0, tag: '0,
                         rt: (exp_r != start_seq), fa: 1'b0};
            if (exp_r == start_seq) begin
              exp_nxt = wrap_seq(e16 + (SEQ_W+1)'(1));
            end
          end
          KIND_STATUS: begin
            emit_req = 1'b1;
            emit_res = '{ev: EV_ACK, seq: pkt_seq_r, len: '0, tag: '0,
                         rt: !in_order, fa: 1'b0};
            if (in_order) begin
              exp_nxt   = wrap_seq(e16 + (SEQ_W+1)'(1));
              state_nxt = S_DELIV;
            end
          end
          KIND_DATA: begin
            if (is_dup) begin
              emit_req = 1'b1;
              emit_res = '{ev: EV_ACK, seq: pkt_seq_r, len: '0, tag: '0,
                           rt: 1'b1, fa: 1'b0};
            end else if (in_order) begin
              emit_req  = 1'b1;
              emit_res  = '{ev: EV_ACK, seq: pkt_seq_r, len: '0, tag: '0,
                            rt: 1'b0, fa: 1'b0};
              exp_nxt   = wrap_seq(e16 + (SEQ_W+1)'(pkt_len_r));
              state_nxt = S_DELIV;
            end else if (is_early) begin
              cnt_nxt   = '0;
              hit_nxt   = 1'b0;
              state_nxt = S_WSCAN;
            end
          end
          KIND_FIN: begin
            if (in_order) begin
              emit_req = 1'b1;
              emit_res = '{ev: EV_ACK, seq: pkt_seq_r, len: '0, tag: '0,
                           rt: 1'b0, fa: 1'b1};
            end
          end
          default: ;
        endcase
      end

      // Deliver the in-order data or status message
      S_DELIV: begin
        if (can_emit) begin
          emit_req = 1'b1;
          emit_res = '{ev: (pkt_kind_r == KIND_STATUS) ? EV_STATUS : EV_DATA,
                       seq: pkt_seq_r, len: pkt_len_r, tag: pkt_tag_r,
                       rt: 1'b0, fa: 1'b0};
          if (pkt_kind_r == KIND_DATA) begin
            cnt_nxt   = '0;
            found_nxt = 1'b0;
            state_nxt = S_DSCAN;
          end else begin
            state_nxt = S_FLUSH;
          end
        end
      end

      // Search the window for a held copy of this sequence
      S_WSCAN: begin
        if (eval && valid_r[rd_idx_r] && (rd_slot.seq == pkt_seq_r)) begin
          hit_nxt = 1'b1;
        end
        if (cnt_r == CNT_W'(WINDOW)) begin
          state_nxt = S_WDEC;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end

      // Ack a duplicate, store new early data, or drop on a full window
      S_WDEC: begin
        state_nxt = S_FLUSH;
        if (hit_r) begin
          emit_req = 1'b1;
          emit_res = '{ev: EV_ACK, seq: pkt_seq_r, len: '0, tag: '0, rt: 1'b1, fa: 1'b0};
        end else if (free_any) begin
          ram_we              = 1'b1;
          valid_nxt[free_idx] = 1'b1;
          emit_req            = 1'b1;
          emit_res = '{ev: EV_ACK, seq: pkt_seq_r, len: '0, tag: '0, rt: 1'b0, fa: 1'b0};
        end
      end

      // Find the lowest held sequence, first slot wins ties
      S_DSCAN: begin
        if (eval && valid_r[rd_idx_r] && (!found_r || (rd_slot.seq < best_r.seq))) begin
          found_nxt    = 1'b1;
          best_idx_nxt = rd_idx_r;
          best_nxt     = rd_slot;
        end
        if (cnt_r == CNT_W'(WINDOW)) begin
          state_nxt = S_DACT;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end

      // Release or drop the lowest entry
      S_DACT: begin
        if (!found_r || (best_r.seq > exp_r)) begin
          state_nxt = S_FLUSH;
        end else if (best_r.seq == exp_r) begin
          if (can_emit) begin
            emit_req                = 1'b1;
            emit_res = '{ev: EV_DATA, seq: best_r.seq, len: best_r.len, tag: best_r.tag,
                         rt: 1'b0, fa: 1'b0};
            exp_nxt                 = wrap_seq(e16 + (SEQ_W+1)'(best_r.len));
            valid_nxt[best_idx_r]   = 1'b0;
            cnt_nxt                 = '0;
            found_nxt               = 1'b0;
            state_nxt               = S_DSCAN;
          end
        end else begin
          valid_nxt[best_idx_r] = 1'b0;
          cnt_nxt               = '0;
          found_nxt             = 1'b0;
          state_nxt             = S_DSCAN;
        end
      end

      // Send the held result marked last
      S_FLUSH: begin
        if (!pend_valid_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          flush_req = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Result path: one held result, then the output register
  always_comb begin
    pend_nxt       = pend_r;
    pend_valid_nxt = pend_valid_r;
    out_res_nxt    = out_res_r;
    out_last_nxt   = out_last_r;
    out_valid_nxt  = out_valid_r && out_stall;
    if (emit_req) begin
      if (pend_valid_r) begin
        out_res_nxt   = pend_r;
        out_last_nxt  = 1'b0;
        out_valid_nxt = 1'b1;
      end
      pend_nxt       = emit_res;
      pend_valid_nxt = 1'b1;
    end else if (flush_req) begin
      out_res_nxt    = pend_r;
      out_last_nxt   = 1'b1;
      out_valid_nxt  = 1'b1;
      pend_valid_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      init_r       <= '0;
      exp_r        <= SEQ_W'(1);
      valid_r      <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      init_r       <= init_nxt;
      exp_r        <= exp_nxt;
      valid_r      <= valid_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pkt_kind_r <= pkt_kind_nxt;
    pkt_seq_r  <= pkt_seq_nxt;
    pkt_len_r  <= pkt_len_nxt;
    pkt_tag_r  <= pkt_tag_nxt;
    cnt_r      <= cnt_nxt;
    rd_idx_r   <= cnt_r[AW-1:0];
    hit_r      <= hit_nxt;
    found_r    <= found_nxt;
    best_idx_r <= best_idx_nxt;
    best_r     <= best_nxt;
    pend_r     <= pend_nxt;
    out_res_r  <= out_res_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_event_res     = out_res_r.ev;
  assign out_ack_seq       = out_res_r.seq;
  assign out_length        = out_res_r.len;
  assign out_tag           = out_res_r.tag;
  assign out_retransmitted = out_res_r.rt;
  assign out_fin_ack       = out_res_r.fa;
  assign out_last          = out_last_r;

endmodule

`default_nettype wire

// ===== rtl/srr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module srr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/srr_checker.sv =====
// Port-level checks of the selective-repeat receiver and their binding.
`default_nettype none

module srr_checker
  import srr_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              cfg_valid,
  input wire logic              cfg_ready,
  input wire logic              in_stall,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic [EV_W-1:0]   out_event_res,
  input wire logic [SEQ_W-1:0]  out_ack_seq,
  input wire logic [LEN_W-1:0]  out_length,
  input wire logic [TAG_W-1:0]  out_tag,
  input wire logic              out_retransmitted,
  input wire logic              out_fin_ack,
  input wire logic              out_last
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_ack_seq) && $stable(out_last))
    else $error("stalled result changed");

  // Acks carry no buffer
  a_ack_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_res == EV_ACK) |-> (out_length == '0) && (out_tag == '0))
    else $error("ack with length or tag");

  // Deliveries carry no ack flags
  a_deliv_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_res != EV_ACK) |-> !out_retransmitted && !out_fin_ack)
    else $error("delivery with ack flags");

  // A fin ack is the only result of its header
  a_fin_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fin_ack |-> out_last)
    else $error("fin ack not last");

  // Configuration is taken only while headers are held off
  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |-> in_stall)
    else $error("header accepted with configuration write");

endmodule

bind selective_repeat_receiver srr_checker u_srr_checker (.*);

`default_nettype wire
